// ----- hw/rtl/worst_fit_block_allocator_core_defines.svh -----
// Assertion macros for the worst-fit allocator.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define WFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WFBA_ASSERT_NOW(lbl, ante, cons, msg)
`define WFBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/wfba_pkg.sv -----
`default_nettype none

package wfba_pkg;

    // Input kind codes
    localparam logic [0:0] KIND_LOAD    = 1'b0;
    localparam logic [0:0] KIND_REQUEST = 1'b1;

    // Fixed field widths
    localparam int COUNT_BITS = 5;
    localparam int INDEX_BITS = 4;
    localparam int VALUE_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wfba_ram.sv -----
`default_nettype none

module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/worst_fit_block_allocator_core.sv -----
`default_nettype none
`include "worst_fit_block_allocator_core_defines.svh"

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------------------
// in      | sink      | in_valid / in_stall     | kind, block_index, size_value, batch_end
// out     | source    | out_valid / out_stall   | granted, chosen_block, remaining_size,
//         |           |                         | batch_end_out
// cfg     | sink      | cfg_valid / cfg_ready   | cfg_data (block_count)
//
// A load transaction writes the free-size RAM directly when it is accepted.
// A request transaction is accepted, then issues one read per block for
// min(block_count, NUM_BLOCKS) blocks through the single RAM read port, compares the last
// entry, and writes back the reduced size and loads the output register.
// Reset clears the per-entry valid bits (an entry never written reads as zero) and sets
// block_count to 16; there is no clearing pass.
// A stalled output holds the request in its final state; input is taken only when idle.

module worst_fit_block_allocator_core #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             kind,
    input  wire logic [wfba_pkg::INDEX_BITS-1:0]  block_index,
    input  wire logic [wfba_pkg::VALUE_BITS-1:0]  size_value,
    input  wire logic                             batch_end,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  granted,
    output logic      [wfba_pkg::INDEX_BITS-1:0]  chosen_block,
    output logic      [wfba_pkg::VALUE_BITS-1:0]  remaining_size,
    output logic                                  batch_end_out,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wfba_pkg::COUNT_BITS-1:0]  cfg_data
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    // State and control
    wfba_pkg::state_t state_reg, state_next;

    logic [wfba_pkg::COUNT_BITS-1:0] count_reg;
    logic [NUM_BLOCKS-1:0]           valid_reg, valid_next;

    // Scan bookkeeping
    logic [CW-1:0]        iss_reg, iss_next;       // next entry to read
    logic [CW-1:0]        limit_reg, limit_next;   // entries to scan
    logic                 cmp_v_reg, cmp_v_next;   // read data valid this cycle
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 bend_reg, bend_next;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    logic                                granted_reg, granted_next;
    logic [wfba_pkg::INDEX_BITS-1:0]     chosen_reg, chosen_next;
    logic [wfba_pkg::VALUE_BITS-1:0]     remain_reg, remain_next;
    logic                                bend_out_reg, bend_out_next;

    // RAM port signals
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    // Datapath helpers
    logic                 in_take;
    logic                 out_free;
    logic                 load_ok;
    logic [AW-1:0]        load_addr;
    logic [SIZE_BITS-1:0] in_size;
    logic [CW-1:0]        limit_in;
    logic [SIZE_BITS-1:0] cmp_val;
    logic                 cmp_hit;
    logic [SIZE_BITS-1:0] left_val;

    wfba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != wfba_pkg::S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Drop loads aimed past the table
    assign load_ok   = (32'(block_index) < NUM_BLOCKS);
    assign load_addr = AW'(block_index);
    assign in_size   = SIZE_BITS'(size_value);

    // Saturate the programmed count to the table depth
    assign limit_in = (32'(count_reg) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(count_reg);

    // Entry never written reads as zero
    assign cmp_val  = valid_reg[cmp_idx_reg] ? ram_rdata : '0;
    // Strictly greater keeps the lowest index on a tie
    assign cmp_hit  = (cmp_val >= size_reg) && (!found_reg || (cmp_val > best_val_reg));
    assign left_val = best_val_reg - size_reg;

    assign ram_raddr = iss_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfba_pkg::S_IDLE;
            count_reg     <= wfba_pkg::COUNT_RESET;
            valid_reg     <= '0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cmp_v_reg     <= cmp_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iss_reg      <= iss_next;
        limit_reg    <= limit_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        size_reg     <= size_next;
        bend_reg     <= bend_next;
        granted_reg  <= granted_next;
        chosen_reg   <= chosen_next;
        remain_reg   <= remain_next;
        bend_out_reg <= bend_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        iss_next       = iss_reg;
        limit_next     = limit_reg;
        cmp_v_next     = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        size_next      = size_reg;
        bend_next      = bend_reg;
        granted_next   = granted_reg;
        chosen_next    = chosen_reg;
        remain_next    = remain_reg;
        bend_out_next  = bend_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = load_addr;
        ram_wdata      = in_size;

        // Fold in the entry read last cycle
        if (cmp_v_reg && cmp_hit)
        begin
            found_next    = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_val_next = cmp_val;
        end

        case (state_reg)
            wfba_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    if (kind == wfba_pkg::KIND_LOAD)
                    begin
                        if (load_ok)
                        begin
                            ram_we                = 1'b1;
                            valid_next[load_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        iss_next   = '0;
                        limit_next = limit_in;
                        found_next = 1'b0;
                        size_next  = in_size;
                        bend_next  = batch_end;
                        state_next = wfba_pkg::S_SCAN;
                    end
                end
            end

            wfba_pkg::S_SCAN:
            begin
                if (iss_reg < limit_reg)
                begin
                    // Issue one read per cycle
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = iss_reg[AW-1:0];
                    iss_next     = iss_reg + CW'(1);
                end
                else
                begin
                    // Last compare happens this cycle
                    state_next = wfba_pkg::S_DONE;
                end
            end

            wfba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        ram_we                   = 1'b1;
                        ram_waddr                = best_idx_reg;
                        ram_wdata                = left_val;
                        valid_next[best_idx_reg] = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    granted_next   = found_reg;
                    chosen_next    = found_reg ? wfba_pkg::INDEX_BITS'(best_idx_reg) : '0;
                    remain_next    = found_reg ? wfba_pkg::VALUE_BITS'(left_val) : '0;
                    bend_out_next  = bend_reg;
                    state_next     = wfba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wfba_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign chosen_block   = chosen_reg;
    assign remaining_size = remain_reg;
    assign batch_end_out  = bend_out_reg;

    `WFBA_ASSERT_NEXT(a_req_starts_scan,
        in_take && (kind == wfba_pkg::KIND_REQUEST),
        state_reg == wfba_pkg::S_SCAN,
        "accepted request did not start a scan")
    `WFBA_ASSERT_NOW(a_best_in_range,
        (state_reg == wfba_pkg::S_DONE) && found_reg,
        CW'(best_idx_reg) < limit_reg,
        "chosen block outside the blocks in use")
    `WFBA_ASSERT_NOW(a_refusal_zero,
        out_valid && !granted,
        (chosen_block == '0) && (remaining_size == '0),
        "refused request carries nonzero fields")
    `WFBA_ASSERT_NOW(a_cmp_in_scan,
        cmp_v_reg,
        (state_reg == wfba_pkg::S_SCAN) && (iss_reg != '0),
        "compare outside a scan")

endmodule

`default_nettype wire
